/* src/utst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package utst_pkg;

  // Offsets and output lengths share one width.
  localparam int OFS_W  = 16;
  localparam int CODE_W = 21;
  localparam int CFG_W  = 8;

  localparam logic [CFG_W-1:0] MIN_RUN_RESET = 8'd2;

  // Lead byte thresholds
  localparam logic [7:0] LEAD4_MIN = 8'hF0;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD2_MIN = 8'hC0;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_KATA  = 2'd1,
    KIND_LATIN = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic             has_token;
    logic [OFS_W-1:0] token_start;
    logic [OFS_W-1:0] token_bytes;
    logic [OFS_W-1:0] token_chars;
    logic             token_class;
    logic             end_of_text;
  } out_t;

  // Decoder to run tracker, for the byte being processed.
  typedef struct packed {
    logic              complete;    // a codepoint finishes on this byte
    logic [CODE_W-1:0] code;        // assembled codepoint
    logic [OFS_W-1:0]  char_start;  // offset of its lead byte
    logic [OFS_W-1:0]  end_offset;  // offset just past this byte, saturated
  } dec_t;

  function automatic kind_t classify(input logic [CODE_W-1:0] cp);
    kind_t k;
    k = KIND_NONE;
    if ((cp >= 21'h030A0 && cp <= 21'h030FF) ||
        (cp >= 21'h031F0 && cp <= 21'h031FF) ||
        (cp >= 21'h0FF66 && cp <= 21'h0FF9F)) begin
      k = KIND_KATA;
    end else if ((cp >= 21'h00041 && cp <= 21'h0005A) ||
                 (cp >= 21'h00061 && cp <= 21'h0007A) ||
                 (cp >= 21'h00030 && cp <= 21'h00039)) begin
      k = KIND_LATIN;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

/* src/utst_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none

module utst_decoder (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic [7:0]      data_byte,
  input  wire logic            last_byte,
  output utst_pkg::dec_t       dec
);
  import utst_pkg::*;

  logic [OFS_W-1:0]  byte_offset;
  logic [1:0]        bytes_left;
  logic [CODE_W-1:0] code_accum;
  logic [OFS_W-1:0]  char_start;

  logic [OFS_W-1:0]  byte_offset_next;
  logic [1:0]        bytes_left_next;
  logic [CODE_W-1:0] code_accum_next;
  logic [OFS_W-1:0]  char_start_next;
  logic              complete;

  always_comb begin
    bytes_left_next = bytes_left;
    code_accum_next = code_accum;
    char_start_next = char_start;
    complete        = 1'b0;
    if (bytes_left == 2'd0) begin
      char_start_next = byte_offset;
      if (data_byte >= LEAD4_MIN) begin
        code_accum_next = {{(CODE_W-3){1'b0}}, data_byte[2:0]};
        bytes_left_next = 2'd3;
      end else if (data_byte >= LEAD3_MIN) begin
        code_accum_next = {{(CODE_W-4){1'b0}}, data_byte[3:0]};
        bytes_left_next = 2'd2;
      end else if (data_byte >= LEAD2_MIN) begin
        code_accum_next = {{(CODE_W-5){1'b0}}, data_byte[4:0]};
        bytes_left_next = 2'd1;
      end else begin
        // ASCII or stray continuation byte: one-byte codepoint
        code_accum_next = {{(CODE_W-8){1'b0}}, data_byte};
        complete        = 1'b1;
      end
    end else begin
      code_accum_next = {code_accum[CODE_W-7:0], data_byte[5:0]};
      bytes_left_next = bytes_left - 2'd1;
      complete        = (bytes_left == 2'd1);
    end
    byte_offset_next = (byte_offset == {OFS_W{1'b1}}) ? byte_offset
                                                       : byte_offset + 1'b1;
  end

  assign dec.complete   = complete;
  assign dec.code       = code_accum_next;
  assign dec.char_start = char_start_next;
  assign dec.end_offset = byte_offset_next;

  // End of text returns the decoder to its reset state.
  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      byte_offset <= '0;
      bytes_left  <= 2'd0;
      code_accum  <= '0;
      char_start  <= '0;
    end else if (step) begin
      byte_offset <= byte_offset_next;
      bytes_left  <= bytes_left_next;
      code_accum  <= code_accum_next;
      char_start  <= char_start_next;
    end
  end

endmodule

`default_nettype wire

/* src/utst_run_tracker.sv */
`timescale 1ns / 1ps
`default_nettype none

module utst_run_tracker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        step,
  input  wire logic                        last_byte,
  input  wire logic [utst_pkg::CFG_W-1:0]  min_run_chars,
  input  wire utst_pkg::dec_t              dec,
  output logic                             has_result,
  output utst_pkg::out_t                   res
);
  import utst_pkg::*;

  kind_t            run_kind;
  logic [OFS_W-1:0] run_start;
  logic [OFS_W-1:0] run_chars;

  kind_t            run_kind_next;
  logic [OFS_W-1:0] run_start_next;
  logic [OFS_W-1:0] run_chars_next;

  kind_t            kind;
  logic [OFS_W-1:0] need;
  logic             qual_old;
  logic             qual_new;
  logic             tok_change;
  logic             tok;
  logic [OFS_W-1:0] t_start;
  logic [OFS_W-1:0] t_end;
  logic [OFS_W-1:0] t_chars;
  kind_t            t_kind;

  always_comb begin
    kind = classify(dec.code);
    // a threshold of zero behaves as one
    need = (min_run_chars == '0) ? {{(OFS_W-1){1'b0}}, 1'b1}
                                 : {{(OFS_W-CFG_W){1'b0}}, min_run_chars};
    qual_old = (run_kind != KIND_NONE) && (run_chars >= need);

    run_kind_next  = run_kind;
    run_start_next = run_start;
    run_chars_next = run_chars;
    tok_change     = 1'b0;
    if (dec.complete && (kind != run_kind)) begin
      tok_change     = qual_old;
      run_kind_next  = kind;
      run_start_next = dec.char_start;
      run_chars_next = (kind != KIND_NONE) ? {{(OFS_W-1){1'b0}}, 1'b1} : '0;
    end else if (dec.complete && (kind != KIND_NONE)) begin
      run_chars_next = (run_chars == {OFS_W{1'b1}}) ? run_chars : run_chars + 1'b1;
    end
    qual_new = (run_kind_next != KIND_NONE) && (run_chars_next >= need);

    // A class change wins over the run that ends the text.
    if (tok_change) begin
      t_start = run_start;
      t_end   = dec.char_start;
      t_chars = run_chars;
      t_kind  = run_kind;
    end else begin
      t_start = run_start_next;
      t_end   = dec.complete ? dec.end_offset : dec.char_start;
      t_chars = run_chars_next;
      t_kind  = run_kind_next;
    end
    tok        = tok_change || (last_byte && qual_new);
    has_result = tok || last_byte;

    res.has_token   = tok;
    res.token_start = tok ? t_start : '0;
    res.token_bytes = (tok && (t_end >= t_start)) ? t_end - t_start : '0;
    res.token_chars = tok ? t_chars : '0;
    res.token_class = tok && (t_kind == KIND_LATIN);
    res.end_of_text = last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      run_kind  <= KIND_NONE;
      run_start <= '0;
      run_chars <= '0;
    end else if (step) begin
      run_kind  <= run_kind_next;
      run_start <= run_start_next;
      run_chars <= run_chars_next;
    end
  end

endmodule

`default_nettype wire

/* src/utf8_script_run_tokenizer.sv */
// Path: a byte is taken into the input register, and its result, if any, is
//   loaded into the result register when the byte is processed; bytes that
//   give no result leave none.
// Throughput: one byte per cycle; the decode, class and run update sit in one
//   register-to-register path, and only a stalled, full result register holds.
// Reset (rst, synchronous): min_run_chars returns to 2, both registers empty,
//   decoder and run state cleared. A final byte clears them again.
`timescale 1ns / 1ps
`default_nettype none

module utf8_script_run_tokenizer (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // configuration: min_run_chars
  input  wire logic                        cfg_we,
  input  wire logic [utst_pkg::CFG_W-1:0]  cfg_wdata,
  // byte input
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire utst_pkg::in_t               in_data,
  // token output
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output utst_pkg::out_t                   out_data
);
  import utst_pkg::*;

  logic [CFG_W-1:0] min_run_chars;

  // input register
  logic in_full;
  in_t  in_item;

  // step: the item in the input register is processed this cycle
  logic step;
  logic in_take;

  dec_t dec;
  logic has_result;
  out_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_run_chars <= MIN_RUN_RESET;
    end else if (cfg_we) begin
      min_run_chars <= cfg_wdata;
    end
  end

  // The input register moves on whenever the result register is empty or is
  // being emptied; items that give no result simply drop out here.
  assign step     = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !step;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item <= in_data;
    end
  end

  utst_decoder u_decoder (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (in_item.data_byte),
    .last_byte (in_item.last_byte),
    .dec       (dec)
  );

  utst_run_tracker u_run_tracker (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .last_byte     (in_item.last_byte),
    .min_run_chars (min_run_chars),
    .dec           (dec),
    .has_result    (has_result),
    .res           (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= has_result;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && has_result) begin
      out_data <= res;
    end
  end

  // Input is only held back by a full, stalled result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");

  // A result without a token only marks the end of the text, with empty fields.
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.has_token) |->
      (out_data.end_of_text && out_data.token_bytes == '0 &&
       out_data.token_chars == '0 && !out_data.token_class))
    else $error("result without token is malformed");

  // A reported token holds at least one codepoint.
  a_token_chars: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.has_token) |-> (out_data.token_chars != '0))
    else $error("token with no codepoints");

endmodule

`default_nettype wire
